// ===== src/awm_pkg.sv =====
// Shared types and constants for the bus activity wake monitor.
`timescale 1ns / 1ps

package awm_pkg;

   localparam logic [31:0] WINDOW_MS  = 32'd1000;
   localparam logic [15:0] RATE_MAX   = 16'hFFFF;
   localparam logic [9:0]  MS_PER_SEC = 10'd1000;

   typedef enum logic [1:0] {
      CSR_GAP_MS         = 2'd0,
      CSR_WAKE_FRAME_MIN = 2'd1,
      CSR_SILENCE_SEC    = 2'd2,
      CSR_MIN_FPS        = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_FRAME = 1'b0,
      KIND_POLL  = 1'b1
   } kind_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] now_ms;
      logic        power_reduced;
      logic [31:0] hold_ms;
   } req_type;

   typedef struct packed {
      logic        wake_request;
      logic        bus_active;
      logic        continuous;
      logic [15:0] frame_rate;
      logic [31:0] frame_count;
   } rsp_type;

endpackage

// ===== src/awm_chan_if.sv =====
// Valid/ready channel carrying one item payload.
`timescale 1ns / 1ps

interface awm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bus_activity_wake_monitor.sv =====
// Bus activity wake monitor: run tracking, wake requests and frame rate windows.
// Each accepted item's result is registered into the output buffer before it reaches rsp_ch.
// One item per cycle while the skid entry is empty; all state updates finish in the accept cycle.
// Results sit in a two-entry output buffer, so req_ch stays ready while one
// result waits on a stalled rsp_ch.
// Synchronous active-high reset clears the state and sets registers to defaults.
`timescale 1ns / 1ps

module bus_activity_wake_monitor (
   input  logic                     clock,
   input  logic                     reset,
   awm_chan_if.sink                 req_ch,
   awm_chan_if.source               rsp_ch,
   input  logic                     csr_we,
   input  awm_pkg::csr_index_type   csr_index,
   input  logic [15:0]              csr_wdata
);
   import awm_pkg::*;

   // configuration
   logic [15:0] gap_ms_ff, wake_frame_min_ff, min_fps_ff;
   logic [7:0]  silence_sec_ff;

   // monitor state
   logic [31:0] last_frame_time_ff, last_frame_time_in;
   logic [31:0] run_start_time_ff, run_start_time_in;
   logic [31:0] frames_seen_ff, frames_seen_in;
   logic [31:0] wake_run_time_ff, wake_run_time_in;
   logic [31:0] wake_run_start_count_ff, wake_run_start_count_in;
   logic        wake_run_consumed_ff, wake_run_consumed_in;
   logic [31:0] window_start_time_ff, window_start_time_in;
   logic [31:0] window_start_count_ff, window_start_count_in;
   logic [15:0] current_rate_ff, current_rate_in;

   // output buffer
   logic    head_valid_ff, head_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type head_ff, head_in;
   rsp_type skid_ff, skid_in;

   logic    push, pop;
   req_type req;
   rsp_type result;
   logic    is_frame;

   logic [31:0] since_last, since_window, delta;
   logic [31:0] silent, held;
   logic        gap_hit, fresh_run, consumed_mid, wake;
   logic [31:0] wake_base;
   logic [17:0] threshold_ms;
   logic        quiet, slow;

   assign req      = req_ch.payload;
   assign is_frame = (req.kind == KIND_FRAME);
   assign req_ch.ready = !skid_valid_ff;
   assign push     = req_ch.valid && req_ch.ready;
   assign pop      = head_valid_ff && rsp_ch.ready;

   // frame arrival
   always_comb begin
      since_last = req.now_ms - last_frame_time_ff;
      gap_hit    = (last_frame_time_ff == 32'd0) || (since_last > {16'd0, gap_ms_ff});

      last_frame_time_in      = last_frame_time_ff;
      run_start_time_in       = run_start_time_ff;
      frames_seen_in          = frames_seen_ff;
      wake_run_time_in        = wake_run_time_ff;
      wake_run_start_count_in = wake_run_start_count_ff;
      wake_run_consumed_in    = wake_run_consumed_ff;
      fresh_run    = 1'b0;
      consumed_mid = wake_run_consumed_ff;
      wake_base    = wake_run_start_count_ff;
      wake         = 1'b0;

      if (is_frame) begin
         if (gap_hit) begin
            run_start_time_in = req.now_ms;
         end
         frames_seen_in     = frames_seen_ff + 32'd1;
         last_frame_time_in = req.now_ms;
         fresh_run = (run_start_time_in != wake_run_time_ff);
         if (fresh_run) begin
            wake_run_time_in        = run_start_time_in;
            wake_run_start_count_in = frames_seen_in;
            consumed_mid            = 1'b0;
            wake_base               = frames_seen_in;
         end
         wake = req.power_reduced && !consumed_mid &&
                ((frames_seen_in - wake_base) >= {16'd0, wake_frame_min_ff});
         wake_run_consumed_in = !req.power_reduced || wake || consumed_mid;
      end
   end

   // poll: rate window
   always_comb begin
      since_window = req.now_ms - window_start_time_ff;
      delta        = frames_seen_ff - window_start_count_ff;
      window_start_time_in  = window_start_time_ff;
      window_start_count_in = window_start_count_ff;
      current_rate_in       = current_rate_ff;
      if (!is_frame) begin
         if (window_start_time_ff == 32'd0) begin
            window_start_time_in  = req.now_ms;
            window_start_count_in = frames_seen_ff;
         end else if (since_window >= WINDOW_MS) begin
            current_rate_in       = (delta[31:16] != 16'd0) ? RATE_MAX : delta[15:0];
            window_start_time_in  = req.now_ms;
            window_start_count_in = frames_seen_ff;
         end
      end
   end

   // result, evaluated on the updated state
   always_comb begin
      silent       = req.now_ms - last_frame_time_in;
      held         = req.now_ms - run_start_time_in;
      threshold_ms = 18'(silence_sec_ff) * 18'(MS_PER_SEC);
      quiet        = silent >= {14'd0, threshold_ms};
      slow         = current_rate_in < min_fps_ff;

      result.wake_request = wake;
      result.bus_active   = (last_frame_time_in != 32'd0) && !(quiet && slow);
      result.continuous   = (last_frame_time_in != 32'd0) &&
                            (silent <= {16'd0, gap_ms_ff}) &&
                            (run_start_time_in != 32'd0) &&
                            (held >= req.hold_ms);
      result.frame_rate   = current_rate_in;
      result.frame_count  = frames_seen_in;
   end

   // two-entry output buffer
   always_comb begin
      head_valid_in = head_valid_ff;
      head_in       = head_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_valid_in = push;
            head_in       = result;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_valid_in = 1'b1;
            head_in       = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = result;
         end
      end
   end

   assign rsp_ch.valid   = head_valid_ff;
   assign rsp_ch.payload = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ms_ff         <= 16'd1000;
         wake_frame_min_ff <= 16'd10;
         silence_sec_ff    <= 8'd10;
         min_fps_ff        <= 16'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_MS:         gap_ms_ff         <= csr_wdata;
            CSR_WAKE_FRAME_MIN: wake_frame_min_ff <= csr_wdata;
            CSR_SILENCE_SEC:    silence_sec_ff    <= csr_wdata[7:0];
            CSR_MIN_FPS:        min_fps_ff        <= csr_wdata;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_frame_time_ff      <= 32'd0;
         run_start_time_ff       <= 32'd0;
         frames_seen_ff          <= 32'd0;
         wake_run_time_ff        <= 32'd0;
         wake_run_start_count_ff <= 32'd0;
         wake_run_consumed_ff    <= 1'b1;
         window_start_time_ff    <= 32'd0;
         window_start_count_ff   <= 32'd0;
         current_rate_ff         <= 16'd0;
      end else if (push) begin
         last_frame_time_ff      <= last_frame_time_in;
         run_start_time_ff       <= run_start_time_in;
         frames_seen_ff          <= frames_seen_in;
         wake_run_time_ff        <= wake_run_time_in;
         wake_run_start_count_ff <= wake_run_start_count_in;
         wake_run_consumed_ff    <= wake_run_consumed_in;
         window_start_time_ff    <= window_start_time_in;
         window_start_count_ff   <= window_start_count_in;
         current_rate_ff         <= current_rate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== src/awm_checker.sv =====
// Port-level assertions for the bus activity wake monitor, with its bind.
`timescale 1ns / 1ps

module awm_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input awm_pkg::rsp_type rsp_payload
);
   import awm_pkg::*;

   logic [31:0] prev_count_ff;
   logic        rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   // frame count of the last delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= 32'd0;
      end else if (rsp_take) begin
         prev_count_ff <= rsp_payload.frame_count;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> (rsp_payload.frame_count == prev_count_ff) ||
                   (rsp_payload.frame_count == prev_count_ff + 32'd1))
      else $error("frame count skipped between items");

   a_wake_on_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_payload.wake_request |->
         rsp_payload.frame_count == prev_count_ff + 32'd1)
      else $error("wake request on an item that was not a frame");

endmodule

bind bus_activity_wake_monitor awm_checker u_awm_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

// ===== tb/tb_bus_activity_wake_monitor.sv =====
// Self-checking testbench for the bus activity wake monitor.
`timescale 1ns / 1ps

import awm_pkg::*;

class wake_status_tracker;
   // register copies
   logic [15:0] gap_ms;
   logic [15:0] wake_min;
   logic [7:0]  silence_s;
   logic [15:0] rate_floor;
   // block state copies
   logic [31:0] last_frame;
   logic [31:0] run_start;
   logic [31:0] frames;
   logic [31:0] wake_run;
   logic [31:0] wake_base;
   logic        wake_spent;
   logic [31:0] win_start;
   logic [31:0] win_base;
   logic [15:0] rate;

   rsp_type status_due[$];
   int accepted;
   int checked;
   int mismatches;
   int wakes;
   int inactive;
   int saturated;

   function new();
      gap_ms     = 16'd1000;
      wake_min   = 16'd10;
      silence_s  = 8'd10;
      rate_floor = 16'd10;
      last_frame = '0;
      run_start  = '0;
      frames     = '0;
      wake_run   = '0;
      wake_base  = '0;
      wake_spent = 1'b1;
      win_start  = '0;
      win_base   = '0;
      rate       = '0;
   endfunction

   function void set_reg(csr_index_type idx, logic [15:0] value);
      case (idx)
         CSR_GAP_MS:         gap_ms = value;
         CSR_WAKE_FRAME_MIN: wake_min = value;
         CSR_SILENCE_SEC:    silence_s = value[7:0];
         CSR_MIN_FPS:        rate_floor = value;
         default: ;
      endcase
   endfunction

   function rsp_type predict_status(req_type r);
      rsp_type     s;
      logic [31:0] since;
      logic [31:0] count_gap;
      logic [31:0] threshold;
      s = '0;
      if (r.kind == KIND_FRAME) begin
         since = r.now_ms - last_frame;
         if (last_frame == 0 || since > {16'h0, gap_ms})
            run_start = r.now_ms;
         frames = frames + 1;
         last_frame = r.now_ms;
         // a run start that differs from the tracked wake run opens a fresh wake opportunity
         if (run_start != wake_run) begin
            wake_run   = run_start;
            wake_base  = frames;
            wake_spent = 1'b0;
         end
         count_gap = frames - wake_base;
         if (!r.power_reduced) begin
            wake_spent = 1'b1;
         end else if (!wake_spent && count_gap >= {16'h0, wake_min}) begin
            s.wake_request = 1'b1;
            wake_spent = 1'b1;
         end
      end else begin
         if (win_start == 0) begin
            win_start = r.now_ms;
            win_base  = frames;
         end else if (r.now_ms - win_start >= WINDOW_MS) begin
            count_gap = frames - win_base;
            rate = (count_gap > {16'h0, RATE_MAX}) ? RATE_MAX : count_gap[15:0];
            win_start = r.now_ms;
            win_base  = frames;
         end
      end
      since = r.now_ms - last_frame;
      threshold = 32'(silence_s) * 32'(MS_PER_SEC);
      if (last_frame != 0)
         s.bus_active = !(since >= threshold && rate < rate_floor);
      if (last_frame != 0 && since <= {16'h0, gap_ms} && run_start != 0 &&
          r.now_ms - run_start >= r.hold_ms)
         s.continuous = 1'b1;
      s.frame_rate  = rate;
      s.frame_count = frames;
      return s;
   endfunction

   function void note_request(req_type r);
      accepted++;
      status_due.push_back(predict_status(r));
   endfunction

   function void check_status(rsp_type got);
      rsp_type want;
      if (status_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] result with no item pending: wake=%0b active=%0b cont=%0b",
                     $time, got.wake_request, got.bus_active, got.continuous,
                     " rate=%0d count=%0d", got.frame_rate, got.frame_count);
         return;
      end
      want = status_due.pop_front();
      checked++;
      if (got.wake_request) wakes++;
      if (!got.bus_active) inactive++;
      if (got.frame_rate == RATE_MAX) saturated++;
      if (got.wake_request !== want.wake_request || got.bus_active !== want.bus_active ||
          got.continuous !== want.continuous || got.frame_rate !== want.frame_rate ||
          got.frame_count !== want.frame_count) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] mismatch on result %0d", $time, checked);
            $display("   expected: wake=%0b active=%0b cont=%0b rate=%0d count=%0d",
                     want.wake_request, want.bus_active, want.continuous,
                     want.frame_rate, want.frame_count);
            $display("   actual:   wake=%0b active=%0b cont=%0b rate=%0d count=%0d",
                     got.wake_request, got.bus_active, got.continuous,
                     got.frame_rate, got.frame_count);
         end
      end
   endfunction

   function int pending();
      return status_due.size();
   endfunction
endclass

module tb_bus_activity_wake_monitor;

   localparam int LONG_STALL  = 300;
   localparam int PHASE_ITEMS = 120;
   localparam int FLOOD_FRAMES = 64;

   logic          clock = 1'b0;
   logic          reset;
   logic          csr_we;
   csr_index_type csr_index;
   logic [15:0]   csr_wdata;

   awm_chan_if #(.payload_type(req_type)) req_ch ();
   awm_chan_if #(.payload_type(rsp_type)) rsp_ch ();

   bus_activity_wake_monitor DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   wake_status_tracker sb;

   logic [31:0] stamp;
   logic        run_reduced;
   int          burst_left;
   int          settings_used;
   bit          long_stall_req;

   always #4 clock = ~clock;

   // item monitor: both channels sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_status(rsp_ch.payload);
      end
   end

   // receiver: ready pattern changes mode every so often
   initial begin
      int mode;
      int span;
      int tick;
      tick = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(20, 200);
         repeat (span) begin
            if (long_stall_req) begin
               long_stall_req = 1'b0;
               rsp_ch.ready <= 1'b0;
               for (int n = 0; n < LONG_STALL; n++) @(posedge clock);
            end
            case (mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= (tick % 3 == 0);
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   initial begin
      #400us;
      $display("** bus_activity_wake_monitor: FAILED **");
      $finish;
   end

   function automatic req_type frame_at(logic [31:0] t, logic reduced, logic [31:0] hold);
      req_type r;
      r.kind = KIND_FRAME;
      r.now_ms = t;
      r.power_reduced = reduced;
      r.hold_ms = hold;
      return r;
   endfunction

   function automatic req_type poll_at(logic [31:0] t, logic [31:0] hold);
      req_type r;
      r.kind = KIND_POLL;
      r.now_ms = t;
      r.power_reduced = 1'($urandom_range(0, 1));
      r.hold_ms = hold;
      return r;
   endfunction

   // mostly time-ordered traffic with runs and breaks, some arbitrary noise
   function automatic req_type next_random_item();
      req_type     r;
      int          pick;
      logic [31:0] step;
      logic [31:0] hold;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.kind = 1'($urandom_range(0, 1));
         r.now_ms = $urandom;
         r.power_reduced = 1'($urandom_range(0, 1));
         r.hold_ms = $urandom;
         return r;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65)      step = $urandom_range(0, sb.gap_ms);
      else if (pick < 80) step = sb.gap_ms + $urandom_range(1, 50);
      else if (pick < 95) step = $urandom_range(1000, 40000);
      else                step = $urandom_range(200000, 400000);
      stamp = stamp + step;
      if ($urandom_range(0, 7) == 0) run_reduced = ~run_reduced;
      pick = $urandom_range(0, 4);
      if (pick < 2)       hold = $urandom_range(0, 3000);
      else if (pick == 2) hold = '0;
      else if (pick == 3) hold = $urandom_range(0, 60000);
      else                hold = $urandom;
      if ($urandom_range(0, 4) == 0) r = poll_at(stamp, hold);
      else                           r = frame_at(stamp, run_reduced, hold);
      return r;
   endfunction

   task automatic offer(input req_type item, input bit allow_gaps);
      int gap;
      if (allow_gaps && burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // drop valid and let every outstanding result come back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] gap, input logic [15:0] wake_min,
                                 input logic [7:0] silence, input logic [15:0] floor_fps);
      write_reg(CSR_GAP_MS, gap);
      write_reg(CSR_WAKE_FRAME_MIN, wake_min);
      write_reg(CSR_SILENCE_SEC, {8'h00, silence});
      write_reg(CSR_MIN_FPS, floor_fps);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      // polls and a frame at time zero, which still reads as never
      offer(poll_at(32'd0, 32'd0), 1'b1);
      offer(frame_at(32'd0, 1'b1, 32'd0), 1'b1);
      offer(poll_at(32'd0, 32'd0), 1'b1);
      offer(poll_at(32'd5, 32'd0), 1'b1);
      // fresh run while reduced: wakes on the 11th frame, once only
      for (int k = 0; k < 12; k++)
         offer(frame_at(32'd100 + 32'(50 * k), 1'b1, 32'(50 * k)), 1'b1);
      offer(poll_at(32'd1100, 32'd0), 1'b1);
      // new run seen while awake
      offer(frame_at(32'd5000, 1'b0, 32'd0), 1'b1);
      // run across the timestamp wrap
      offer(frame_at(32'hFFFF_FF00, 1'b1, 32'hFFFF_FFFF), 1'b1);
      offer(frame_at(32'h0000_0010, 1'b1, 32'h0000_0110), 1'b1);
      // long silence, then a slow window
      offer(poll_at(32'd30016, 32'hFFFF_FFFF), 1'b1);
      offer(poll_at(32'd61016, 32'd0), 1'b1);
      stamp = 32'd61016;
   endtask

   task automatic run_random(input int count, input bit pressure);
      for (int n = 0; n < count; n++) begin
         if (pressure && n == count / 2) begin
            long_stall_req = 1'b1;
            for (int k = 0; k < 24; k++) offer(next_random_item(), 1'b0);
         end
         offer(next_random_item(), 1'b1);
      end
   endtask

   // a dense burst of frames inside one window, then a slow window
   task automatic run_rate_flood();
      logic [31:0] base;
      base = 32'h1000_0000;
      offer(poll_at(base, 32'd0), 1'b1);
      offer(poll_at(base + 32'd1000, 32'd0), 1'b1);
      for (int i = 0; i < FLOOD_FRAMES; i++)
         offer(frame_at(base + 32'd1000 + 32'(i >> 6), 1'($urandom_range(0, 1)), $urandom),
               1'b0);
      offer(poll_at(base + 32'd2500, 32'd0), 1'b1);
      offer(poll_at(base + 32'd3600, 32'd0), 1'b1);
      stamp = base + 32'd3600;
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_GAP_MS;
      csr_wdata      = '0;
      stamp          = '0;
      run_reduced    = 1'b1;
      burst_left     = 0;
      settings_used  = 1;
      long_stall_req = 1'b0;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(PHASE_ITEMS, 1'b1);
      drain();
      apply_settings(16'd0, 16'd1, 8'd0, 16'd0);
      run_random(PHASE_ITEMS, 1'b0);
      drain();
      apply_settings(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
      run_random(PHASE_ITEMS, 1'b0);
      drain();
      apply_settings(16'd300, 16'd3, 8'd2, 16'd5);
      run_random(PHASE_ITEMS, 1'b1);
      drain();
      // zero wake threshold, timestamps close to the wrap
      apply_settings(16'd500, 16'd0, 8'd1, 16'd2000);
      stamp = 32'hFFFF_F000;
      run_random(PHASE_ITEMS, 1'b0);
      drain();
      apply_settings(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 20)),
                     8'($urandom_range(0, 60)), 16'($urandom_range(0, 50)));
      run_random(PHASE_ITEMS, 1'b0);
      drain();
      apply_settings(16'd1000, 16'd10, 8'd10, 16'hFFFF);
      run_rate_flood();
      drain();
      repeat (10) @(posedge clock);

      $display("Run: %0d items over %0d register settings, %0d results checked.",
               sb.accepted, settings_used, sb.checked);
      $display("Seen: %0d wake requests, %0d inactive-bus results, %0d saturated rates.",
               sb.wakes, sb.inactive, sb.saturated);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** bus_activity_wake_monitor: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
         $display("** bus_activity_wake_monitor: FAILED **");
      end
      $finish;
   end

endmodule

// ===== bus_activity_wake_monitor.f =====
src/awm_pkg.sv
src/awm_chan_if.sv
src/bus_activity_wake_monitor.sv
src/awm_checker.sv
tb/tb_bus_activity_wake_monitor.sv
